/* design/message_slot_queue_manager_unit_defines.svh */
// ----------------------------------------------------------------------------
// message_slot_queue_manager_unit_defines
// Assertion macros used by the mailbox sequencer.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_SLOT_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define MESSAGE_SLOT_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define MSQ_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define MSQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* design/msqm_pkg.sv */
// ----------------------------------------------------------------------------
// msqm_pkg
// Status codes and command types shared by the mailbox controller and datapath.
// ----------------------------------------------------------------------------
package msqm_pkg;
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_ARG   = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_TOO_SMALL = 3'd5;
  localparam logic       OP_SEND      = 1'b0;
  localparam logic       OP_RECV      = 1'b1;
  localparam logic       CFG_NUM_RANKS   = 1'b0;
  localparam logic       CFG_MAX_PENDING = 1'b1;

  typedef struct packed {
    logic take;
    logic recv_start;
    logic recv_byte;
    logic recv_done;
  } msqm_cmd_t;

  typedef struct packed {
    logic recv_ok;
    logic recv_last;
    logic emit_busy;
  } msqm_stat_t;
endpackage

/* design/msqm_ram.sv */
// ----------------------------------------------------------------------------
// msqm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msqm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/msqm_datapath.sv */
// ----------------------------------------------------------------------------
// msqm_datapath
// Slot lists, queue tables, payload memory and the result register.
// ----------------------------------------------------------------------------
module msqm_datapath import msqm_pkg::*; #(
  parameter int NUM_SLOTS     = 16,
  parameter int MAX_RANKS     = 16,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  msqm_cmd_t   cmd,
  output msqm_stat_t  stat,
  input  logic        operation,
  input  logic [3:0]  rank,
  input  logic [3:0]  dest_rank,
  input  logic [6:0]  message_count,
  input  logic [7:0]  data_byte,
  input  logic [4:0]  num_ranks,
  input  logic [4:0]  max_pending,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [3:0]  source_rank,
  output logic [6:0]  length,
  output logic [7:0]  out_byte,
  output logic        last
);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RW = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int BW = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  logic [SW-1:0] slot_next   [NUM_SLOTS];
  logic [3:0]    slot_source [NUM_SLOTS];
  logic [6:0]    slot_length [NUM_SLOTS];
  logic [SW-1:0] free_head, free_tail;
  logic [CW-1:0] free_count;
  logic [SW-1:0] queue_head    [MAX_RANKS];
  logic [SW-1:0] queue_tail    [MAX_RANKS];
  logic [4:0]    queue_pending [MAX_RANKS];
  logic [SW-1:0] fill_slot;
  logic [6:0]    fill_index;
  logic [RW-1:0] fill_dest;

  logic [SW-1:0] rx_slot;
  logic [6:0]    rx_len;
  logic [3:0]    rx_src;
  logic [BW-1:0] rx_idx;
  logic          rx_pend;
  logic          last_byte_q;

  logic          pay_we;
  logic [SW+BW-1:0] pay_waddr, pay_raddr;
  logic [7:0]    pay_rdata;

  logic [RW-1:0] d_idx, r_idx;
  logic          dest_ok, rank_ok, cnt_ok;
  logic [SW-1:0] s_cur;
  logic [6:0]    len_cur;
  logic          completes;
  logic [6:0]    head_len;

  assign d_idx   = RW'(dest_rank);
  assign r_idx   = RW'(rank);
  assign dest_ok = ({1'b0, dest_rank} < num_ranks) && (32'(dest_rank) < MAX_RANKS);
  assign rank_ok = ({1'b0, rank} < num_ranks) && (32'(rank) < MAX_RANKS);
  assign cnt_ok  = (message_count >= 7'd1) && (32'(message_count) <= MAX_MSG_BYTES);
  assign s_cur   = (fill_index == 7'd0) ? free_head : fill_slot;
  assign len_cur = (fill_index == 7'd0) ? message_count : slot_length[fill_slot];
  assign completes = (fill_index + 7'd1) >= len_cur;
  assign head_len = (32'(slot_length[queue_head[r_idx]]) > MAX_MSG_BYTES) ?
                    7'(MAX_MSG_BYTES) : slot_length[queue_head[r_idx]];

  logic send_ok;
  assign send_ok = (fill_index != 7'd0) ||
                   (cnt_ok && dest_ok && free_count != '0 &&
                    queue_pending[d_idx] < max_pending);

  assign pay_we    = cmd.take && operation == OP_SEND && send_ok &&
                     32'(fill_index) < MAX_MSG_BYTES;
  assign pay_waddr = {s_cur, fill_index[BW-1:0]};
  assign pay_raddr = {rx_slot, rx_idx};

  msqm_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS * MAX_MSG_BYTES)) u_payload (
    .clk(clk), .we(pay_we), .waddr(pay_waddr), .wdata(data_byte),
    .re(cmd.recv_byte), .raddr(pay_raddr), .rdata(pay_rdata)
  );

  assign stat.emit_busy = out_valid && out_stall;
  assign stat.recv_last = 32'(rx_idx) + 1 >= 32'(rx_len);
  assign stat.recv_ok   = rank_ok && queue_pending[r_idx] != '0 &&
                          !(message_count < head_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_next[i] <= SW'((i + 1) % NUM_SLOTS);
      for (int i = 0; i < MAX_RANKS; i++) begin
        queue_head[i] <= '0;
        queue_tail[i] <= '0;
        queue_pending[i] <= '0;
      end
      free_head  <= '0;
      free_tail  <= SW'(NUM_SLOTS - 1);
      free_count <= CW'(NUM_SLOTS);
      fill_slot  <= '0;
      fill_index <= '0;
      fill_dest  <= '0;
      out_valid  <= 1'b0;
      rx_pend    <= 1'b0;
      rx_idx     <= '0;
      last_byte_q <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.take && operation == OP_SEND) begin
        out_valid <= 1'b1;
        last <= 1'b1; source_rank <= '0; out_byte <= '0;
        length <= len_cur;
        if (fill_index == 7'd0 && !(cnt_ok && dest_ok)) status <= ST_BAD_ARG;
        else if (fill_index == 7'd0 && free_count == '0) status <= ST_NO_SLOT;
        else if (fill_index == 7'd0 && queue_pending[d_idx] >= max_pending)
          status <= ST_FULL;
        else begin
          status <= ST_OK;
          if (fill_index == 7'd0) begin
            free_head  <= slot_next[free_head];
            free_count <= free_count - CW'(1);
            fill_slot  <= free_head;
            fill_dest  <= d_idx;
            slot_source[free_head] <= rank;
            slot_length[free_head] <= message_count;
          end
          if (completes) begin
            logic [RW-1:0] d;
            d = (fill_index == 7'd0) ? d_idx : fill_dest;
            if (queue_pending[d] == '0) queue_head[d] <= s_cur;
            else slot_next[queue_tail[d]] <= s_cur;
            queue_tail[d] <= s_cur;
            queue_pending[d] <= queue_pending[d] + 5'd1;
            fill_index <= '0;
          end else begin
            fill_index <= fill_index + 7'd1;
          end
        end
      end
      if (cmd.take && operation == OP_RECV) begin
        out_valid <= 1'b1; last <= 1'b1; source_rank <= '0; out_byte <= '0;
        if (!rank_ok) begin
          status <= ST_BAD_ARG; length <= '0;
        end else if (queue_pending[r_idx] == '0) begin
          status <= ST_EMPTY; length <= '0;
        end else if (message_count < head_len) begin
          status <= ST_TOO_SMALL; length <= head_len;
        end else begin
          out_valid <= 1'b0;
          rx_slot <= queue_head[r_idx];
          rx_len  <= head_len;
          rx_src  <= slot_source[queue_head[r_idx]];
          rx_idx  <= '0;
          queue_head[r_idx] <= slot_next[queue_head[r_idx]];
          queue_pending[r_idx] <= queue_pending[r_idx] - 5'd1;
        end
      end
      if (cmd.recv_byte) begin
        rx_pend <= 1'b1;
        last_byte_q <= stat.recv_last;
        if (!stat.recv_last) rx_idx <= rx_idx + BW'(1);
      end else if (rx_pend && !stat.emit_busy) begin
        rx_pend <= 1'b0;
      end
      if (rx_pend && !stat.emit_busy) begin
        out_valid <= 1'b1; status <= ST_OK; source_rank <= rx_src;
        length <= rx_len; out_byte <= pay_rdata;
        last <= last_byte_q;
      end
      if (cmd.recv_done) begin
        if (free_count == '0) free_head <= rx_slot;
        else slot_next[free_tail] <= rx_slot;
        free_tail  <= rx_slot;
        free_count <= free_count + CW'(1);
      end
    end
  end
endmodule

/* design/msqm_ctrl.sv */
// ----------------------------------------------------------------------------
// msqm_ctrl
// Sequencer: takes items and steps a receive through its payload bytes.
// ----------------------------------------------------------------------------
module msqm_ctrl import msqm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operation,
  input  logic       recv_go,
  input  msqm_stat_t stat,
  output msqm_cmd_t  cmd
);
  `include "message_slot_queue_manager_unit_defines.svh"
  typedef enum logic [1:0] {IDLE, READ, WAIT} state_t;
  state_t state;
  logic   last_issued;

  assign in_stall = (state != IDLE) || stat.emit_busy;
  assign cmd.take = in_valid && !in_stall;
  assign cmd.recv_start = cmd.take && operation == OP_RECV && recv_go;
  assign cmd.recv_byte = (state == READ) && !stat.emit_busy;
  assign cmd.recv_done = cmd.recv_byte && stat.recv_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      last_issued <= 1'b0;
    end else begin
      case (state)
        IDLE: if (cmd.recv_start) state <= READ;
        READ: if (cmd.recv_done) state <= WAIT;
        WAIT: if (!stat.emit_busy) state <= IDLE;
        default: state <= IDLE;
      endcase
      last_issued <= cmd.recv_done;
    end
  end

  `MSQ_ASSERT_IMPL(a_no_take_busy, clk, rst, state != IDLE, !cmd.take)
  `MSQ_ASSERT_NEXT(a_start_reads, clk, rst, cmd.recv_start, state == READ)
  `MSQ_ASSERT_NEXT(a_done_waits, clk, rst, cmd.recv_done, state == WAIT && last_issued)
endmodule

/* design/message_slot_queue_manager_unit.sv */
// ----------------------------------------------------------------------------
// message_slot_queue_manager_unit
// Mailbox engine with a linked free list and per-receiver message queues.
// ----------------------------------------------------------------------------
// A send word gives one result word. A receive of an n-byte message gives one
// result word per byte, read through the single read port of the payload
// memory at one byte a cycle while out_stall is low; errors give one word.
module message_slot_queue_manager_unit import msqm_pkg::*; #(
  parameter int NUM_SLOTS     = 16,
  parameter int MAX_RANKS     = 16,
  parameter int MAX_MSG_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operation,
  input  logic [3:0] rank,
  input  logic [3:0] dest_rank,
  input  logic [6:0] message_count,
  input  logic [7:0] data_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [3:0] source_rank,
  output logic [6:0] length,
  output logic [7:0] out_byte,
  output logic       last
);
  logic [4:0] num_ranks, max_pending;
  msqm_cmd_t  cmd;
  msqm_stat_t stat;
  logic       recv_go;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_ranks <= 5'd16;
      max_pending <= 5'd16;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_NUM_RANKS) num_ranks <= cfg_data;
      else max_pending <= cfg_data;
    end
  end

  assign recv_go = stat.recv_ok;

  msqm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .recv_go(recv_go), .stat(stat), .cmd(cmd)
  );

  msqm_datapath #(.NUM_SLOTS(NUM_SLOTS), .MAX_RANKS(MAX_RANKS),
                  .MAX_MSG_BYTES(MAX_MSG_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .operation(operation),
    .rank(rank), .dest_rank(dest_rank), .message_count(message_count),
    .data_byte(data_byte), .num_ranks(num_ranks), .max_pending(max_pending),
    .out_stall(out_stall), .out_valid(out_valid), .status(status),
    .source_rank(source_rank), .length(length), .out_byte(out_byte), .last(last)
  );
endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mailbox engine. A directed table covers the
// bad-argument, full, empty and too-small codes and the extremes of the
// fields; random phases under several register settings follow. Every result
// word is checked against an in-bench model of the slot lists.
// ----------------------------------------------------------------------------
module tb import msqm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int BYTES = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0] st;
    logic [3:0] src;
    logic [6:0] len;
    logic [7:0] b;
    logic       lst;
  } mb_word_t;

  typedef struct {
    bit         is_cfg;
    logic       op;
    logic [3:0] rk;
    logic [3:0] dst;
    logic [6:0] cnt;
    logic [7:0] db;
    bit         fixed;
    logic [2:0] st;
    logic [6:0] len;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       operation = OP_SEND;
  logic [3:0] rank = '0;
  logic [3:0] dest_rank = '0;
  logic [6:0] message_count = '0;
  logic [7:0] data_byte = '0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = CFG_NUM_RANKS;
  logic [4:0] cfg_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] status;
  logic [3:0] source_rank;
  logic [6:0] length;
  logic [7:0] out_byte;
  logic       last;

  bit         row_fixed = 1'b0;
  logic [2:0] row_st = '0;
  logic [6:0] row_len = '0;
  bit         quiet = 1'b0;
  int         errors = 0;
  int         idle_cycles = 0;

  logic [4:0] nranks_q;
  logic [4:0] maxpend_q;
  logic [3:0] nxt [SLOTS];
  logic [3:0] ssrc [SLOTS];
  logic [6:0] slen [SLOTS];
  logic [7:0] spay [SLOTS][BYTES];
  logic [3:0] fhead, ftail, fslot, fdest, qhead [16], qtail [16];
  logic [4:0] fcount, qpend [16];
  logic [6:0] fidx;
  mb_word_t   expected_words [$];

  row_t table_rows [] = '{
    '{0, OP_RECV, 0, 0, 64, 0, 1, ST_EMPTY, 0},
    '{0, OP_SEND, 1, 2, 0, 8'h11, 1, ST_BAD_ARG, 0},
    '{0, OP_SEND, 1, 0, 65, 8'h22, 1, ST_BAD_ARG, 65},
    '{0, OP_SEND, 1, 0, 127, 8'h33, 1, ST_BAD_ARG, 127},
    '{0, OP_SEND, 15, 0, 1, 8'hFF, 1, ST_OK, 1},
    '{0, OP_RECV, 0, 0, 0, 0, 1, ST_TOO_SMALL, 1},
    '{0, OP_RECV, 0, 0, 127, 0, 0, 0, 0},
    '{0, OP_SEND, 0, 15, 2, 8'h00, 1, ST_OK, 2},
    '{0, OP_RECV, 15, 0, 64, 0, 1, ST_EMPTY, 0},
    '{0, OP_SEND, 9, 3, 5, 8'hA5, 1, ST_OK, 2},
    '{0, OP_RECV, 15, 0, 2, 0, 0, 0, 0},
    '{1, CFG_NUM_RANKS, 0, 0, 1, 0, 0, 0, 0},
    '{1, CFG_MAX_PENDING, 0, 0, 1, 0, 0, 0, 0},
    '{0, OP_SEND, 2, 1, 3, 8'h44, 1, ST_BAD_ARG, 3},
    '{0, OP_SEND, 2, 0, 1, 8'h5A, 1, ST_OK, 1},
    '{0, OP_SEND, 2, 0, 1, 8'h66, 1, ST_FULL, 1},
    '{0, OP_RECV, 1, 0, 64, 0, 1, ST_BAD_ARG, 0},
    '{0, OP_RECV, 0, 0, 64, 0, 0, 0, 0},
    '{1, CFG_NUM_RANKS, 0, 0, 16, 0, 0, 0, 0},
    '{1, CFG_MAX_PENDING, 0, 0, 16, 0, 0, 0, 0},
    '{0, OP_SEND, 3, 7, 64, 8'h00, 1, ST_OK, 64}
  };

  message_slot_queue_manager_unit DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic mb_word_t mk(logic [2:0] st, logic [3:0] src, logic [6:0] len,
                                  logic [7:0] b, logic lst);
    mk = '{st: st, src: src, len: len, b: b, lst: lst};
  endfunction

  function automatic bit rank_ok(logic [3:0] r);
    rank_ok = ({1'b0, r} < nranks_q);
  endfunction

  task automatic reset_mailbox();
    nranks_q = 16;
    maxpend_q = 16;
    for (int i = 0; i < SLOTS; i++) begin
      nxt[i] = 4'(i + 1);
      ssrc[i] = '0;
      slen[i] = '0;
      for (int j = 0; j < BYTES; j++) spay[i][j] = '0;
    end
    for (int r = 0; r < 16; r++) begin
      qhead[r] = '0;
      qtail[r] = '0;
      qpend[r] = '0;
    end
    fhead = 0;
    ftail = 15;
    fcount = 16;
    fslot = 0;
    fdest = 0;
    fidx = 0;
  endtask

  task automatic predict_mailbox(logic op, logic [3:0] rk, logic [3:0] dst, logic [6:0] cnt,
                                 logic [7:0] db, bit fx, logic [2:0] fst, logic [6:0] flen);
    mb_word_t res [$];
    logic [3:0] s;
    logic [6:0] ln;
    if (op == OP_SEND) begin
      if (fidx == 0 && (cnt < 1 || cnt > BYTES || !rank_ok(dst))) begin
        res.push_back(mk(ST_BAD_ARG, 0, cnt, 0, 1));
      end else if (fidx == 0 && fcount == 0) begin
        res.push_back(mk(ST_NO_SLOT, 0, cnt, 0, 1));
      end else if (fidx == 0 && qpend[dst] >= maxpend_q) begin
        res.push_back(mk(ST_FULL, 0, cnt, 0, 1));
      end else begin
        if (fidx == 0) begin
          s = fhead;
          fhead = nxt[s];
          fcount--;
          fslot = s;
          fdest = dst;
          ssrc[s] = rk;
          slen[s] = cnt;
        end
        s = fslot;
        ln = slen[s];
        spay[s][fidx[5:0]] = db;
        fidx++;
        if (fidx >= ln) begin
          if (qpend[fdest] == 0) qhead[fdest] = s;
          else nxt[qtail[fdest]] = s;
          qtail[fdest] = s;
          qpend[fdest]++;
          fidx = 0;
        end
        res.push_back(mk(ST_OK, 0, ln, 0, 1));
      end
    end else begin
      if (!rank_ok(rk)) begin
        res.push_back(mk(ST_BAD_ARG, 0, 0, 0, 1));
      end else if (qpend[rk] == 0) begin
        res.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
      end else begin
        s = qhead[rk];
        ln = slen[s];
        if (cnt < ln) begin
          res.push_back(mk(ST_TOO_SMALL, 0, ln, 0, 1));
        end else begin
          qhead[rk] = nxt[s];
          qpend[rk]--;
          for (int i = 0; i < ln; i++) begin
            res.push_back(mk(ST_OK, ssrc[s], ln, spay[s][i], (i + 1 == ln)));
          end
          if (fcount == 0) fhead = s;
          else nxt[ftail] = s;
          ftail = s;
          fcount++;
        end
      end
    end
    if (fx) res[0] = mk(fst, 0, flen, 0, 1);
    foreach (res[i]) expected_words.push_back(res[i]);
  endtask

  always @(posedge clk) begin
    mb_word_t e;
    if (rst) begin
      reset_mailbox();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_RANKS) nranks_q = cfg_data;
        else maxpend_q = cfg_data;
      end
      if (in_valid && !in_stall) begin
        predict_mailbox(operation, rank, dest_rank, message_count, data_byte,
                        row_fixed, row_st, row_len);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: status %0d length %0d", status, length);
          errors++;
        end else begin
          e = expected_words.pop_front();
          if (status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, status);
            errors++;
          end
          if (source_rank !== e.src) begin
            $error("source_rank: expected %0d, got %0d", e.src, source_rank);
            errors++;
          end
          if (length !== e.len) begin
            $error("length: expected %0d, got %0d", e.len, length);
            errors++;
          end
          if (out_byte !== e.b) begin
            $error("out_byte: expected %0d, got %0d", e.b, out_byte);
            errors++;
          end
          if (last !== e.lst) begin
            $error("last: expected %0d, got %0d", e.lst, last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 10);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic put_word(logic op, logic [3:0] rk, logic [3:0] dst, logic [6:0] cnt,
                          logic [7:0] db, bit fx, logic [2:0] st, logic [6:0] len);
    if (!quiet && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    rank <= rk;
    dest_rank <= dst;
    message_count <= cnt;
    data_byte <= db;
    row_fixed <= fx;
    row_st <= st;
    row_len <= len;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_mailbox();
    in_valid <= 1'b0;
    row_fixed <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [4:0] val);
    drain_mailbox();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_word(int recv_pct);
    logic [3:0] rk, dst;
    logic [6:0] cnt;
    int pick;
    rk = ($urandom_range(99) < 85) ? 4'($urandom_range(nranks_q - 1)) : 4'($urandom_range(15));
    dst = ($urandom_range(99) < 85) ? 4'($urandom_range(nranks_q - 1)) : 4'($urandom_range(15));
    if ($urandom_range(99) < recv_pct && (fidx == 0 || $urandom_range(9) == 0)) begin
      cnt = ($urandom_range(99) < 20) ? 7'($urandom_range(127)) : 7'($urandom_range(64, 127));
      put_word(OP_RECV, rk, dst, cnt, 8'($urandom), 0, 0, 0);
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) cnt = 7'($urandom_range(1, 6));
      else if (pick < 78) cnt = 64;
      else if (pick < 88) cnt = 7'($urandom_range(7, 63));
      else if (pick < 93) cnt = 0;
      else cnt = 7'($urandom_range(127));
      put_word(OP_SEND, rk, dst, cnt, 8'($urandom), 0, 0, 0);
    end
  endtask

  initial begin
    logic [4:0] pr [6] = '{16, 1, 16, 1, 4, 16};
    logic [4:0] pp [6] = '{16, 1, 4, 16, 16, 16};
    int rp [6] = '{40, 40, 45, 40, 40, 15};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        write_reg(table_rows[i].op, table_rows[i].cnt[4:0]);
      end else begin
        put_word(table_rows[i].op, table_rows[i].rk, table_rows[i].dst, table_rows[i].cnt,
                 table_rows[i].db, table_rows[i].fixed, table_rows[i].st, table_rows[i].len);
      end
    end
    for (int p = 0; p < 6; p++) begin
      if (p == 3) begin
        pr[p] = 5'($urandom_range(1, 16));
        pp[p] = 5'($urandom_range(1, 16));
      end
      write_reg(CFG_NUM_RANKS, pr[p]);
      write_reg(CFG_MAX_PENDING, pp[p]);
      quiet = (p == 2);
      repeat (80) random_word(rp[p]);
    end
    quiet = 1'b0;
    drain_mailbox();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/msqm_pkg.sv
design/msqm_ram.sv
design/msqm_datapath.sv
design/msqm_ctrl.sv
design/message_slot_queue_manager_unit.sv
verif/tb.sv
